// ----- src/psr_pkg.sv -----
// Package for the processor symmetry refiner.
// Holds the operation codes and the fixed field widths; no dependencies.
package psr_pkg;

	// Width of the state mask field (one bit per processor it can name)
	localparam int MASK_W   = 8;
	// Width of the class count field in a result beat
	localparam int COUNT_W  = 4;
	// Width of the input and output tdata buses
	localparam int TDATA_W  = 8;

	// Operation carried in the input tuser
	typedef enum logic [0:0] {
		OP_ASSIGN = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

endpackage

// ----- src/psr_core.sv -----
// Single-pass refine and query logic for the processor symmetry refiner.
// Purely combinational; depends on psr_pkg for op_t and the mask width.
module psr_core #(
	parameter int PROCS = 8,
	parameter int LBL_W = 3,
	parameter int TOT_W = 4
) (
	input  psr_pkg::op_t                op,
	input  logic [psr_pkg::MASK_W-1:0]  mask,
	input  logic [PROCS-1:0][LBL_W-1:0] label,
	input  logic [TOT_W-1:0]            total,
	input  logic                        flag,
	output logic [PROCS-1:0][LBL_W-1:0] label_nxt,
	output logic [TOT_W-1:0]            total_nxt,
	output logic                        flag_nxt,
	output logic                        allowed
);
	import psr_pkg::*;

	logic [PROCS-1:0]            used;
	logic [PROCS-1:0]            has_used;
	logic [PROCS-1:0]            has_unused;
	logic [PROCS-1:0]            split;
	logic [PROCS-1:0][TOT_W-1:0] rank;
	logic                        any_used;
	logic                        stray_bits;
	logic                        conflict;

	// Processors that the mask marks as used; processors past the mask width never are
	always_comb begin
		for (int i = 0; i < PROCS; i++) begin
			if (i < MASK_W) begin
				used[i] = mask[i];
			end else begin
				used[i] = 1'b0;
			end
		end
		any_used = |used;
	end

	// Mask bits that name no processor
	always_comb begin
		stray_bits = 1'b0;
		for (int b = 0; b < MASK_W; b++) begin
			if (b >= PROCS && mask[b]) begin
				stray_bits = 1'b1;
			end
		end
	end

	// Per class: does it hold used and unused members, and is it split
	always_comb begin
		for (int c = 0; c < PROCS; c++) begin
			has_used[c]   = 1'b0;
			has_unused[c] = 1'b0;
			for (int i = 0; i < PROCS; i++) begin
				if (label[i] == LBL_W'(c)) begin
					if (used[i]) begin
						has_used[c] = 1'b1;
					end else begin
						has_unused[c] = 1'b1;
					end
				end
			end
			split[c] = has_used[c] && has_unused[c] && (op == OP_ASSIGN);
		end
	end

	// Rank of each class among the split ones: offset of its fresh number
	always_comb begin
		logic [PROCS-1:0] lower;
		for (int c = 0; c < PROCS; c++) begin
			lower = '0;
			for (int j = 0; j < PROCS; j++) begin
				if (j < c) begin
					lower[j] = split[j];
				end
			end
			rank[c] = TOT_W'($countones(lower));
		end
	end

	// Unused members of a split class move to that class's fresh number
	always_comb begin
		for (int i = 0; i < PROCS; i++) begin
			if (split[label[i]] && !used[i]) begin
				label_nxt[i] = LBL_W'(total + rank[label[i]]);
			end else begin
				label_nxt[i] = label[i];
			end
		end
		total_nxt = total + TOT_W'($countones(split));
		flag_nxt  = flag || ((op == OP_ASSIGN) && any_used && (total_nxt == TOT_W'(PROCS)));
	end

	// Query: a used member may not follow an unused member of its own class
	always_comb begin
		conflict = 1'b0;
		for (int i = 0; i < PROCS; i++) begin
			for (int j = 0; j < PROCS; j++) begin
				if (j < i && used[i] && !used[j] && (label[i] == label[j])) begin
					conflict = 1'b1;
				end
			end
		end
		allowed = (op == OP_QUERY) && any_used && !stray_bits && !conflict;
	end

endmodule

// ----- src/processor_symmetry_refiner_top.sv -----
// Top level of the processor symmetry refiner: input register, class state, result register.
// Depends on psr_pkg and psr_core.
//
// The block keeps the processors split into classes of interchangeable processors
// (one class at reset). An assign beat (tuser = 0) splits every class that has both
// used and unused processors in the mask; a query beat (tuser = 1) reports whether
// the mask is allowed. Every input beat yields exactly one result beat carrying
// allowed, the class count and the no-symmetry flag. One beat is taken per clock unless
// the result register holds a beat that m_tready does not take: a beat is held in the
// input register, the refine/query logic updates the class labels in one pass, and the
// result lands in the output register. The loop from the label registers through the
// refine logic and back is what sets the one-beat-per-cycle rate.
module processor_symmetry_refiner_top #(
	parameter int PROCS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [psr_pkg::TDATA_W-1:0]  s_tdata,  // [7:0] state_mask
	input  logic                         s_tuser,  // [0] operation
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [psr_pkg::TDATA_W-1:0]  m_tdata   // [0] allowed, [4:1] class_count,
	                                               // [5] no-symmetry flag, [7:6] zero
);
	import psr_pkg::*;

	localparam int LBL_W = (PROCS > 1) ? $clog2(PROCS) : 1;
	localparam int TOT_W = $clog2(PROCS + 1);

	// class state
	logic [PROCS-1:0][LBL_W-1:0] label_q;
	logic [TOT_W-1:0]            total_q;
	logic                        flag_q;

	// input stage
	logic                        valid_s1;
	op_t                         op_s1;
	logic [MASK_W-1:0]           mask_s1;

	// result stage
	logic                        valid_s2;
	logic                        allowed_s2;
	logic [COUNT_W-1:0]          count_s2;
	logic                        nosym_s2;

	logic [PROCS-1:0][LBL_W-1:0] label_nxt;
	logic [TOT_W-1:0]            total_nxt;
	logic                        flag_nxt;
	logic                        allowed;
	logic                        advance;

	// Handshake: stage 1 moves on whenever the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	psr_core #(
		.PROCS (PROCS),
		.LBL_W (LBL_W),
		.TOT_W (TOT_W)
	) u_core (
		.op        (op_s1),
		.mask      (mask_s1),
		.label     (label_q),
		.total     (total_q),
		.flag      (flag_q),
		.label_nxt (label_nxt),
		.total_nxt (total_nxt),
		.flag_nxt  (flag_nxt),
		.allowed   (allowed)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= op_t'(s_tuser);
			mask_s1 <= s_tdata[MASK_W-1:0];
		end
	end

	// Class state, updated as each beat leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_q <= '0;
			total_q <= TOT_W'(1);
			flag_q  <= 1'b0;
		end else if (advance) begin
			label_q <= label_nxt;
			total_q <= total_nxt;
			flag_q  <= flag_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			allowed_s2 <= allowed;
			count_s2   <= COUNT_W'(total_nxt);
			nosym_s2   <= flag_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, nosym_s2, count_s2, allowed_s2};

	// Class count stays within the processor count
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q >= TOT_W'(1)) && (total_q <= TOT_W'(PROCS)))
		else $error("class count out of range");

	// Classes never merge
	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (total_q >= $past(total_q)))
		else $error("class count decreased");

	// No-symmetry flag is sticky and means every processor is alone
	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		flag_q |=> flag_q)
		else $error("no-symmetry flag cleared");

	a_flag_full: assert property (@(posedge clk) disable iff (!arst_n)
		flag_q |-> (total_q == TOT_W'(PROCS)))
		else $error("no-symmetry flag with shared classes");

	// Every label names an existing class
	for (genvar g = 0; g < PROCS; g++) begin : g_lbl_chk
		a_label_range: assert property (@(posedge clk) disable iff (!arst_n)
			TOT_W'(label_q[g]) < total_q)
			else $error("label beyond class count");
	end

endmodule
